>>> rtl/igais_pkg.sv
// Shared types and constants for the IMU gyro/accel interpolation sync unit.
package igais_pkg;
	localparam int AXIS_W = 32;
	localparam int MAG_W = 33;
	localparam int NUM_AXES = 3;

	localparam logic MODE_GYRO = 1'b0;
	localparam logic MODE_ACCEL = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DROP,
		ST_CHECK,
		ST_DIV,
		ST_OUT
	} state_t;

	// handshake between sequencer and divider lanes
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage

>>> rtl/igais_lane.sv
// One interpolation lane: prev + (cur - prev) * num / den, bit-serial restoring divide.
module igais_lane import igais_pkg::*; #(
	parameter int TIME_WIDTH = 48
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [AXIS_W-1:0]     prev,
	input  logic signed [AXIS_W-1:0]     cur,
	input  logic        [TIME_WIDTH-1:0] num,
	input  logic        [TIME_WIDTH-1:0] den,
	output logic                         done,
	output logic signed [AXIS_W-1:0]     result
);
	localparam int BW = $clog2(MAG_W + 1);

	logic [MAG_W-1:0]       mag_q;
	logic [MAG_W-1:0]       quo_q;
	logic [TIME_WIDTH:0]    rem_q;
	logic                   neg_q;
	logic [BW-1:0]          bit_q;
	logic                   run_q;
	logic signed [AXIS_W:0] diff;
	logic [TIME_WIDTH+1:0]  s1;
	logic [TIME_WIDTH+1:0]  s2;
	logic [TIME_WIDTH+1:0]  r1;
	logic [TIME_WIDTH+1:0]  r2;
	logic                   q1;
	logic                   q2;
	logic signed [AXIS_W:0] sum;

	assign diff = {cur[AXIS_W-1], cur} - {prev[AXIS_W-1], prev};

	// shift rem, subtract den if it fits; on a set mag bit add num, subtract again
	always_comb begin
		s1 = {rem_q, 1'b0};
		q1 = (s1 >= {2'b00, den});
		r1 = q1 ? s1 - {2'b00, den} : s1;
		s2 = r1 + {2'b00, num};
		q2 = mag_q[MAG_W-1] && (s2 >= {2'b00, den});
		r2 = mag_q[MAG_W-1] ? (q2 ? s2 - {2'b00, den} : s2) : r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			bit_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				bit_q <= BW'(MAG_W - 1);
				rem_q <= '0;
				quo_q <= '0;
				neg_q <= diff[AXIS_W];
				mag_q <= diff[AXIS_W] ? MAG_W'(-diff) : MAG_W'(diff);
			end else if (run_q) begin
				quo_q <= quo_q + quo_q + MAG_W'(q1) + MAG_W'(q2);
				rem_q <= r2[TIME_WIDTH:0];
				mag_q <= {mag_q[MAG_W-2:0], 1'b0};
				bit_q <= bit_q - BW'(1);
				if (bit_q == '0) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	assign sum = neg_q ? {prev[AXIS_W-1], prev} - $signed({1'b0, quo_q[AXIS_W-1:0]})
			   : {prev[AXIS_W-1], prev} + $signed({1'b0, quo_q[AXIS_W-1:0]});
	assign result = sum[AXIS_W-1:0];
endmodule

>>> rtl/imu_gyro_accel_interpolate_sync_unit.sv
// Top level: gyro FIFO, accel sequencer, three divider lanes and result register.
//  channel | dir | handshake               | payload
//  in      | in  | in_valid / in_ready     | mode, sample_time, axis_x/y/z
//  out     | out | out_valid / out_ready   | out_time, accel_x/y/z, rate_x/y/z, last_of_run
// Gyro item: accepted, then the FIFO read port is left to settle before the next item is taken.
// Accel item: accept and settle, then pop and settle per discarded entry, then per result
// a 33-step bit-serial divide in the three axis lanes side by side, plus start, load,
// hand-off and next-entry fetch, and any output wait; a first or stale one is just taken.
// Reset clears FIFO pointers, count and previous-sample flag; the store needs no clear.
// A stalled output holds the sequencer; no new item is taken until the run ends.
module imu_gyro_accel_interpolate_sync_unit import igais_pkg::*; #(
	parameter int FIFO_DEPTH = 16,
	parameter int TIME_WIDTH = 48,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         mode,
	input  logic        [TIME_WIDTH-1:0] sample_time,
	input  logic signed [AXIS_W-1:0]     axis_x,
	input  logic signed [AXIS_W-1:0]     axis_y,
	input  logic signed [AXIS_W-1:0]     axis_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic        [TIME_WIDTH-1:0] out_time,
	output logic signed [AXIS_W-1:0]     accel_x,
	output logic signed [AXIS_W-1:0]     accel_y,
	output logic signed [AXIS_W-1:0]     accel_z,
	output logic signed [AXIS_W-1:0]     rate_x,
	output logic signed [AXIS_W-1:0]     rate_y,
	output logic signed [AXIS_W-1:0]     rate_z,
	output logic                         last_of_run
);
	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = $clog2(FIFO_DEPTH + 1);
	localparam int FW = TIME_WIDTH + 3 * AXIS_W;
	// scale-free interpolation: fraction width only documents the format
	localparam int UNUSED_FRAC = FRAC_BITS;

	logic [FW-1:0]         mem [FIFO_DEPTH];
	logic [FW-1:0]         rd_q;
	logic [TIME_WIDTH-1:0] nx_time_q;
	logic [AW-1:0]         head_q, tail_q;
	logic [CW-1:0]         count_q;
	logic                  have_prev_q;
	logic [TIME_WIDTH-1:0] ptime_q, ctime_q;
	logic signed [AXIS_W-1:0] px_q, py_q, pz_q, cx_q, cy_q, cz_q;
	state_t                state_q, state_d;
	logic                  rd_wait_q;
	div_ctl_t              dctl;
	logic [TIME_WIDTH-1:0] tg, num, den;
	logic                  dx, dy, dz;
	logic signed [AXIS_W-1:0] ix, iy, iz;
	logic                  in_acc, gyro_wr, accel_go, pop, more;
	logic [AW-1:0]         head_nx;

	assign in_acc   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE) && !rd_wait_q && !out_valid;
	assign gyro_wr  = in_acc && (mode == MODE_GYRO) && (count_q < CW'(FIFO_DEPTH));
	assign accel_go = in_acc && (mode == MODE_ACCEL) && have_prev_q && (sample_time > ptime_q);
	assign tg  = rd_q[FW-1 -: TIME_WIDTH];
	assign num = (tg > ptime_q) ? tg - ptime_q : '0;
	assign den = ctime_q - ptime_q;
	assign head_nx = (head_q == AW'(FIFO_DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign pop = !rd_wait_q && count_q != '0 &&
		((state_q == ST_DROP && tg < ptime_q) ||
		 (state_q == ST_OUT && out_valid && out_ready));
	assign more = count_q != '0 && tg < ctime_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accel_go) state_d = ST_DROP;
			ST_DROP:  if (!rd_wait_q && !(count_q != '0 && tg < ptime_q)) state_d = ST_CHECK;
			ST_CHECK: if (!rd_wait_q) state_d = more ? ST_DIV : ST_IDLE;
			ST_DIV:   if (dx) state_d = ST_OUT;
			ST_OUT:   if (out_valid && out_ready) state_d = ST_CHECK;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		dctl.start = (state_q == ST_CHECK) && !rd_wait_q && more;
		dctl.busy  = (state_q == ST_DIV);
		dctl.done  = dx && dy && dz;
	end

	// second read port tracks the entry after head for the last flag
	always_ff @(posedge clk) begin
		if (gyro_wr) mem[tail_q] <= {sample_time, axis_x, axis_y, axis_z};
		rd_q <= mem[pop ? head_nx : head_q];
		nx_time_q <= mem[head_nx][FW-1 -: TIME_WIDTH];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			have_prev_q <= 1'b0;
			ptime_q     <= '0;
			px_q <= '0; py_q <= '0; pz_q <= '0;
			rd_wait_q   <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_wait_q <= gyro_wr || pop || accel_go;
			if (gyro_wr) begin
				tail_q <= (tail_q == AW'(FIFO_DEPTH - 1)) ? '0 : tail_q + AW'(1);
			end
			if (pop) head_q <= head_nx;
			count_q <= count_q + CW'(gyro_wr) - CW'(pop);
			if (in_acc && mode == MODE_ACCEL && (!have_prev_q || sample_time > ptime_q)) begin
				ctime_q <= sample_time;
				cx_q <= axis_x; cy_q <= axis_y; cz_q <= axis_z;
				if (!have_prev_q) begin
					have_prev_q <= 1'b1;
					ptime_q <= sample_time;
					px_q <= axis_x; py_q <= axis_y; pz_q <= axis_z;
				end
			end
			// run over: promote the current sample
			if (state_q == ST_CHECK && !rd_wait_q && !more) begin
				ptime_q <= ctime_q;
				px_q <= cx_q; py_q <= cy_q; pz_q <= cz_q;
			end
			if (state_q == ST_DIV && dctl.done) begin
				out_valid <= 1'b1;
				out_time  <= tg;
				accel_x <= ix; accel_y <= iy; accel_z <= iz;
				rate_x <= rd_q[3*AXIS_W-1 -: AXIS_W];
				rate_y <= rd_q[2*AXIS_W-1 -: AXIS_W];
				rate_z <= rd_q[AXIS_W-1:0];
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// last flag: next queued entry would not be emitted
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && dctl.done)
			last_of_run <= !(count_q > CW'(1) && nx_time_q < ctime_q);
	end

	igais_lane #(.TIME_WIDTH(TIME_WIDTH)) u_lane_x (
		.clk, .arst_n, .start(dctl.start), .prev(px_q), .cur(cx_q),
		.num, .den, .done(dx), .result(ix));
	igais_lane #(.TIME_WIDTH(TIME_WIDTH)) u_lane_y (
		.clk, .arst_n, .start(dctl.start), .prev(py_q), .cur(cy_q),
		.num, .den, .done(dy), .result(iy));
	igais_lane #(.TIME_WIDTH(TIME_WIDTH)) u_lane_z (
		.clk, .arst_n, .start(dctl.start), .prev(pz_q), .cur(cz_q),
		.num, .den, .done(dz), .result(iz));

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(FIFO_DEPTH)) else $error("fifo count overflow");
	a_lanes_sync: assert property (@(posedge clk) disable iff (!arst_n)
		dx == dy && dy == dz) else $error("lanes out of step");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_time))
		else $error("result dropped");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		dctl.busy |-> !in_ready) else $error("item taken mid run");
	a_frac: assert property (@(posedge clk) UNUSED_FRAC > 0) else $error("bad format");
endmodule
